@@ rtl/rgs_pkg.sv @@
package rgs_pkg;

  localparam int LOG_DEPTH = 20;
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int AGE_W     = 5;
  localparam int IDX_W     = ((LOG_AW > AGE_W) ? LOG_AW : AGE_W) + 1;

  localparam int WEIGHT_W  = 12;
  localparam int TICKS_W   = 16;
  localparam int SEC_W     = 17;
  localparam int PRE_W     = 10;
  localparam int CNT_W     = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MS_PER_SECOND   = 1000;
  localparam int SECONDS_PER_DAY = 24 * 3600;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_TICKS  = 3'd4;

  localparam logic [1:0] DISP_OFF     = 2'd0;
  localparam logic [1:0] DISP_WAITING = 2'd1;
  localparam logic [1:0] DISP_REPORT  = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PRODUCT = 2'd1,
    OP_TOGGLE  = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_PASS   = 2'd1,
    RES_REJECT = 2'd2
  } result_t;

  typedef enum logic [2:0] {
    GATE_IDLE = 3'b001,
    GATE_FWD  = 3'b010,
    GATE_REV  = 3'b100
  } gate_t;

  typedef enum logic [2:0] {
    VIEW_OFF     = 3'b001,
    VIEW_WAITING = 3'b010,
    VIEW_REPORT  = 3'b100
  } view_t;

  typedef struct packed {
    logic [TICKS_W-1:0] forward_ticks;
    logic [TICKS_W-1:0] reverse_ticks;
    logic [TICKS_W-1:0] report_ticks;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             pass;
    logic [AGE_W-1:0] age;
  } qitem_t;

  typedef struct packed {
    logic [SEC_W-1:0] entry_time;
    logic             entry_passed;
    logic             entry_valid;
    logic [1:0]       last_result;
    logic [CNT_W-1:0] rejected_products;
    logic [CNT_W-1:0] passed_products;
    logic [CNT_W-1:0] total_products;
    logic [1:0]       display_mode;
    logic             gate_reverse;
    logic             gate_forward;
    logic             lamp_reject;
    logic             lamp_pass;
  } result_item_t;

  localparam int OUT_BITS   = $bits(result_item_t);
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int IN_BITS    = WEIGHT_W + AGE_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

endpackage

@@ rtl/rgs_front.sv @@
module rgs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rgs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              q_push,
  input  logic                              q_full,
  output rgs_pkg::qitem_t                   q_item,
  output rgs_pkg::cfg_t                     cfg
);

  logic [rgs_pkg::WEIGHT_W-1:0] weight_low_r, weight_high_r;
  logic [rgs_pkg::TICKS_W-1:0]  forward_r, reverse_r, report_r;
  logic [rgs_pkg::WEIGHT_W-1:0] weight;
  logic                         cfg_we;

  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_low_r  <= 12'd100;
      weight_high_r <= 12'd3000;
      forward_r     <= 16'd500;
      reverse_r     <= 16'd800;
      report_r      <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgs_pkg::CFG_WEIGHT_LOW:    weight_low_r  <= cfg_data[rgs_pkg::WEIGHT_W-1:0];
        rgs_pkg::CFG_WEIGHT_HIGH:   weight_high_r <= cfg_data[rgs_pkg::WEIGHT_W-1:0];
        rgs_pkg::CFG_FORWARD_TICKS: forward_r     <= cfg_data;
        rgs_pkg::CFG_REVERSE_TICKS: reverse_r     <= cfg_data;
        rgs_pkg::CFG_REPORT_TICKS:  report_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign weight    = in_tdata[rgs_pkg::WEIGHT_W-1:0];
  assign in_tready = rst_n & ~q_full;
  assign q_push    = in_tvalid & in_tready;

  always_comb begin
    q_item.op   = rgs_pkg::op_t'(in_tuser);
    q_item.pass = (weight >= weight_low_r) && (weight <= weight_high_r);
    q_item.age  = in_tdata[rgs_pkg::WEIGHT_W +: rgs_pkg::AGE_W];
  end

  assign cfg.forward_ticks = forward_r;
  assign cfg.reverse_ticks = reverse_r;
  assign cfg.report_ticks  = report_r;

endmodule

@@ rtl/rgs_queue.sv @@
module rgs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rgs_pkg::qitem_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output rgs_pkg::qitem_t head
);

  rgs_pkg::qitem_t slot_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;
  logic            do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_pop    = pop & not_empty;
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push)   wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

@@ rtl/rgs_back.sv @@
module rgs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_not_empty,
  input  rgs_pkg::qitem_t                q_head,
  output logic                           q_pop,
  input  rgs_pkg::cfg_t                  cfg,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rgs_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int LA = rgs_pkg::LOG_AW;
  localparam int IW = rgs_pkg::IDX_W;

  logic [rgs_pkg::PRE_W-1:0]   pre_r, pre_nxt;
  logic [rgs_pkg::SEC_W-1:0]   sec_r, sec_nxt;
  logic                        powered_r, powered_nxt;
  logic [rgs_pkg::CNT_W-1:0]   total_r, total_nxt;
  logic [rgs_pkg::CNT_W-1:0]   npass_r, npass_nxt;
  logic [rgs_pkg::CNT_W-1:0]   nrej_r, nrej_nxt;
  rgs_pkg::result_t            last_r, last_nxt;
  rgs_pkg::gate_t              gate_r, gate_nxt;
  logic [rgs_pkg::TICKS_W-1:0] gate_tmr_r, gate_tmr_nxt;
  rgs_pkg::view_t              view_r, view_nxt;
  logic [rgs_pkg::TICKS_W-1:0] rep_tmr_r, rep_tmr_nxt;
  logic [rgs_pkg::LOG_DEPTH-1:0] log_valid_r, log_valid_nxt;
  logic [LA-1:0]               slot_r, slot_nxt;
  logic [rgs_pkg::SEC_W:0]     log_data_r [rgs_pkg::LOG_DEPTH];
  logic                        log_we;

  logic                        out_valid_r;
  rgs_pkg::result_item_t       out_r, out_nxt;

  logic                        fire;
  logic [rgs_pkg::TICKS_W-1:0] gate_inc, rep_inc;
  logic [IW-1:0]               rd_sum;
  logic [LA-1:0]               rd_idx;
  logic                        e_valid, e_passed;
  logic [rgs_pkg::SEC_W-1:0]   e_time;

  assign q_pop = ~out_valid_r | out_tready;
  assign fire  = q_not_empty & q_pop;

  assign gate_inc = gate_tmr_r + 16'd1;
  assign rep_inc  = rep_tmr_r + 16'd1;

  always_comb begin
    rd_sum = IW'(slot_r) + IW'(q_head.age);
    if (rd_sum >= IW'(rgs_pkg::LOG_DEPTH)) rd_sum = rd_sum - IW'(rgs_pkg::LOG_DEPTH);
  end
  assign rd_idx = rd_sum[LA-1:0];

  always_comb begin
    pre_nxt       = pre_r;
    sec_nxt       = sec_r;
    powered_nxt   = powered_r;
    total_nxt     = total_r;
    npass_nxt     = npass_r;
    nrej_nxt      = nrej_r;
    last_nxt      = last_r;
    gate_nxt      = gate_r;
    gate_tmr_nxt  = gate_tmr_r;
    view_nxt      = view_r;
    rep_tmr_nxt   = rep_tmr_r;
    log_valid_nxt = log_valid_r;
    slot_nxt      = slot_r;
    log_we        = 1'b0;
    e_valid       = 1'b0;
    e_passed      = 1'b0;
    e_time        = '0;
    if (fire) begin
      unique case (q_head.op)
        rgs_pkg::OP_TICK: begin
          if (pre_r == rgs_pkg::PRE_W'(rgs_pkg::MS_PER_SECOND - 1)) begin
            pre_nxt = '0;
            if (sec_r == rgs_pkg::SEC_W'(rgs_pkg::SECONDS_PER_DAY - 1)) sec_nxt = '0;
            else sec_nxt = sec_r + 17'd1;
          end else begin
            pre_nxt = pre_r + 10'd1;
          end
          unique case (gate_r)
            rgs_pkg::GATE_FWD: begin
              gate_tmr_nxt = gate_inc;
              if (gate_inc >= cfg.forward_ticks) begin
                gate_nxt     = rgs_pkg::GATE_REV;
                gate_tmr_nxt = '0;
              end
            end
            rgs_pkg::GATE_REV: begin
              gate_tmr_nxt = gate_inc;
              if (gate_inc >= cfg.reverse_ticks) begin
                gate_nxt     = rgs_pkg::GATE_IDLE;
                gate_tmr_nxt = '0;
              end
            end
            default: ;
          endcase
          if (view_r == rgs_pkg::VIEW_REPORT) begin
            rep_tmr_nxt = rep_inc;
            if (rep_inc >= cfg.report_ticks) begin
              view_nxt    = rgs_pkg::VIEW_WAITING;
              rep_tmr_nxt = '0;
            end
          end
        end
        rgs_pkg::OP_PRODUCT: begin
          if (powered_r) begin
            total_nxt = total_r + 32'd1;
            if (q_head.pass) begin
              npass_nxt = npass_r + 32'd1;
              last_nxt  = rgs_pkg::RES_PASS;
            end else begin
              nrej_nxt     = nrej_r + 32'd1;
              last_nxt     = rgs_pkg::RES_REJECT;
              gate_nxt     = rgs_pkg::GATE_FWD;
              gate_tmr_nxt = '0;
            end
            log_we                = 1'b1;
            log_valid_nxt[slot_r] = 1'b1;
            slot_nxt = (slot_r == LA'(rgs_pkg::LOG_DEPTH - 1)) ? '0 : slot_r + LA'(1);
            view_nxt    = rgs_pkg::VIEW_REPORT;
            rep_tmr_nxt = '0;
          end
        end
        rgs_pkg::OP_TOGGLE: begin
          powered_nxt   = ~powered_r;
          total_nxt     = '0;
          npass_nxt     = '0;
          nrej_nxt      = '0;
          last_nxt      = rgs_pkg::RES_NONE;
          gate_nxt      = rgs_pkg::GATE_IDLE;
          gate_tmr_nxt  = '0;
          rep_tmr_nxt   = '0;
          log_valid_nxt = '0;
          slot_nxt      = '0;
          view_nxt      = powered_r ? rgs_pkg::VIEW_OFF : rgs_pkg::VIEW_WAITING;
        end
        rgs_pkg::OP_READ: begin
          if (IW'(q_head.age) < IW'(rgs_pkg::LOG_DEPTH) && log_valid_r[rd_idx]) begin
            e_valid  = 1'b1;
            e_passed = log_data_r[rd_idx][rgs_pkg::SEC_W];
            e_time   = log_data_r[rd_idx][rgs_pkg::SEC_W-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    out_nxt.lamp_pass   = (view_nxt == rgs_pkg::VIEW_REPORT) && (last_nxt == rgs_pkg::RES_PASS);
    out_nxt.lamp_reject = (view_nxt == rgs_pkg::VIEW_REPORT) &&
                          (last_nxt == rgs_pkg::RES_REJECT);
    out_nxt.gate_forward = (gate_nxt == rgs_pkg::GATE_FWD);
    out_nxt.gate_reverse = (gate_nxt == rgs_pkg::GATE_REV);
    unique case (view_nxt)
      rgs_pkg::VIEW_WAITING: out_nxt.display_mode = rgs_pkg::DISP_WAITING;
      rgs_pkg::VIEW_REPORT:  out_nxt.display_mode = rgs_pkg::DISP_REPORT;
      default:               out_nxt.display_mode = rgs_pkg::DISP_OFF;
    endcase
    out_nxt.total_products    = total_nxt;
    out_nxt.passed_products   = npass_nxt;
    out_nxt.rejected_products = nrej_nxt;
    out_nxt.last_result       = last_nxt;
    out_nxt.entry_valid       = e_valid;
    out_nxt.entry_passed      = e_passed;
    out_nxt.entry_time        = e_time;
  end

  always_ff @(posedge clk) begin
    if (log_we) log_data_r[slot_r] <= {q_head.pass, sec_r};
    if (fire)   out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r       <= '0;
      sec_r       <= '0;
      powered_r   <= 1'b0;
      total_r     <= '0;
      npass_r     <= '0;
      nrej_r      <= '0;
      last_r      <= rgs_pkg::RES_NONE;
      gate_r      <= rgs_pkg::GATE_IDLE;
      gate_tmr_r  <= '0;
      view_r      <= rgs_pkg::VIEW_OFF;
      rep_tmr_r   <= '0;
      log_valid_r <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pre_r       <= pre_nxt;
      sec_r       <= sec_nxt;
      powered_r   <= powered_nxt;
      total_r     <= total_nxt;
      npass_r     <= npass_nxt;
      nrej_r      <= nrej_nxt;
      last_r      <= last_nxt;
      gate_r      <= gate_nxt;
      gate_tmr_r  <= gate_tmr_nxt;
      view_r      <= view_nxt;
      rep_tmr_r   <= rep_tmr_nxt;
      log_valid_r <= log_valid_nxt;
      slot_r      <= slot_nxt;
      if (fire)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(rgs_pkg::OUT_DATA_W - rgs_pkg::OUT_BITS)'(0), out_r};

endmodule

@@ rtl/reject_gate_sequencer_top.sv @@
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tuser: func; tdata: weight_sample, entry_age
// out_    | out | out_tvalid/tready  | tdata: lamps, gate, display, counters, entry
// cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
// One item per cycle sustained while out_tready stays high; an accepted item is first
// written into the queue and then registered at the output by the back stage.
// Each item updates state in the single back stage.
// Synchronous active-low reset; log valid bits clear at once, no clearing pass.
// Two-entry queue decouples in_tready from out_tready; in_tready and cfg_ready low in reset.
module reject_gate_sequencer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [11:0] weight_sample, [16:12] entry_age, rest zero
  input  logic [rgs_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] lamp_pass, [1] lamp_reject, [2] gate_forward, [3] gate_reverse,
  // [5:4] display_mode, [37:6] total_products, [69:38] passed_products,
  // [101:70] rejected_products, [103:102] last_result, [104] entry_valid,
  // [105] entry_passed, [122:106] entry_time, rest zero
  output logic [rgs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic            q_push, q_full, q_pop, q_not_empty;
  rgs_pkg::qitem_t q_item, q_head;
  rgs_pkg::cfg_t   cfg;

  rgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_item    (q_item),
    .cfg       (cfg)
  );

  rgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rgs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .cfg         (cfg),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
